>>> src/thi_pkg.sv
// Package with shared constants and types of the timestamped history interpolator.
`default_nettype none
package thi_pkg;
    localparam int HISTORY_DEPTH = 64;
    localparam int ALPHA_BITS = 16;
    localparam int SNAP_W = 32 * 4 + 24 * 5;
    localparam logic [23:0] HISTORY_WINDOW_RST = 24'd1000000;
    localparam logic [23:0] RECORD_INTERVAL_RST = 24'd16667;
    localparam logic [0:0] CFG_HISTORY_WINDOW = 1'b0;
    localparam logic [0:0] CFG_RECORD_INTERVAL = 1'b1;
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    typedef struct packed {
        logic [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [23:0] pitch;
        logic signed [23:0] yaw;
        logic signed [23:0] roll;
        logic [23:0] hh;
        logic [23:0] rad;
    } t_snap;
endpackage
`default_nettype wire

>>> src/thi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module thi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/timestamped_history_interpolator.sv
// Top level of the timestamped pose history with linear interpolation.
// A record stores its entry and then drops expired entries one by one, each with a read
// state and a check state, before it answers. A query reads the oldest and newest entries,
// scans back from the newest entry with one RAM read per step (up to HISTORY_DEPTH - 1 pairs),
// divides for alpha one quotient bit per cycle and interpolates the eight fields one after
// another, each with a multiply state and an add state. All snapshots live in one RAM with
// a single read port. The result sits in an output register, so the next transfer can start
// while it waits; a finished item then waits until the previous result has been taken.
`default_nettype none
module timestamped_history_interpolator #(
    parameter int HISTORY_DEPTH = thi_pkg::HISTORY_DEPTH,
    parameter int ALPHA_BITS = thi_pkg::ALPHA_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_req_type,
    input  wire [31:0]        i_event_time,
    input  wire signed [31:0] i_pos_x,
    input  wire signed [31:0] i_pos_y,
    input  wire signed [31:0] i_pos_z,
    input  wire signed [23:0] i_pitch,
    input  wire signed [23:0] i_yaw,
    input  wire signed [23:0] i_roll,
    input  wire [23:0]        i_half_height,
    input  wire [23:0]        i_radius,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [0:0]         i_cfg_index,
    input  wire [23:0]        i_cfg_data,
    output logic              o_valid,
    input  wire               i_ready,
    output logic              o_found,
    output logic [31:0]       o_out_time,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [23:0] o_out_pitch,
    output logic signed [23:0] o_out_yaw,
    output logic signed [23:0] o_out_roll,
    output logic [23:0]       o_out_half_height,
    output logic [23:0]       o_out_radius
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int NW = 33 + ALPHA_BITS;
    localparam int AB = $clog2(ALPHA_BITS + 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DROP_RD = 4'd1;
    localparam logic [3:0] S_DROP_CK = 4'd2;
    localparam logic [3:0] S_Q_OLD = 4'd3;
    localparam logic [3:0] S_Q_OLDCK = 4'd4;
    localparam logic [3:0] S_Q_NEWCK = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_DIV = 4'd7;
    localparam logic [3:0] S_LERP_MUL = 4'd8;
    localparam logic [3:0] S_LERP_ADD = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;
    localparam logic [3:0] S_Q_NEW = 4'd11;

    logic [3:0] r_state;
    logic [23:0] r_window, r_interval;
    logic [AW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic [31:0] r_last;
    logic r_have;
    logic [31:0] r_t;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_k;
    thi_pkg::t_snap r_a, r_b, r_res;
    logic r_found;
    logic [NW-1:0] r_rem;
    logic [32:0] r_span;
    logic [ALPHA_BITS:0] r_alpha;
    logic [AB-1:0] r_bit;
    logic [3:0] r_fld;
    logic signed [33+ALPHA_BITS:0] r_prod;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    thi_pkg::t_snap ram_wdata, rd;
    logic [thi_pkg::SNAP_W-1:0] rd_bits;

    assign rd = thi_pkg::t_snap'(rd_bits);

    thi_ram #(.WIDTH(thi_pkg::SNAP_W), .DEPTH(HISTORY_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(rd_bits)
    );

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {1'b0, CW'(base)} + {1'b0, k};
        if (s >= (CW+1)'(HISTORY_DEPTH)) begin
            s = s - (CW+1)'(HISTORY_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(HISTORY_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic signed [33:0] f_field_a(input thi_pkg::t_snap s,
                                                     input logic [3:0] f);
        logic signed [33:0] v;
        case (f)
            4'd0: v = 34'(s.x);
            4'd1: v = 34'(s.y);
            4'd2: v = 34'(s.z);
            4'd3: v = 34'(s.pitch);
            4'd4: v = 34'(s.yaw);
            4'd5: v = 34'(s.roll);
            4'd6: v = $signed({10'd0, s.hh});
            default: v = $signed({10'd0, s.rad});
        endcase
        return v;
    endfunction

    wire in_acc = i_valid && o_ready;
    wire out_acc = o_valid && i_ready;
    wire [32:0] gate = {1'b0, r_last} + {9'd0, r_interval};
    wire [32:0] old_plus = {1'b0, rd.t} + {9'd0, r_window};

    logic signed [33:0] fa, fb, fdiff, fq;
    logic [33+ALPHA_BITS:0] mag;
    always_comb begin
        fa = f_field_a(r_a, r_fld);
        fb = f_field_a(r_b, r_fld);
        fdiff = fb - fa;
        mag = r_prod[33+ALPHA_BITS] ? (34+ALPHA_BITS)'(-r_prod) : r_prod;
        if (r_prod[33+ALPHA_BITS]) begin
            fq = -$signed(34'((mag + (34+ALPHA_BITS)'((1 << ALPHA_BITS) - 1)) >> ALPHA_BITS));
        end else begin
            fq = $signed(34'(mag >> ALPHA_BITS));
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = f_slot(r_oldest, r_count);
        ram_wdata = '{i_event_time, i_pos_x, i_pos_y, i_pos_z, i_pitch, i_yaw, i_roll,
                      i_half_height, i_radius};
        ram_raddr = r_idx;
        if (r_state == S_IDLE && in_acc && i_req_type == thi_pkg::REQ_RECORD
            && !(r_have && {1'b0, i_event_time} < gate)) begin
            ram_we = 1'b1;
            if (r_count == CW'(HISTORY_DEPTH)) begin
                ram_waddr = r_oldest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_window <= thi_pkg::HISTORY_WINDOW_RST;
            r_interval <= thi_pkg::RECORD_INTERVAL_RST;
            r_oldest <= '0;
            r_count <= '0;
            r_last <= '0;
            r_have <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == thi_pkg::CFG_HISTORY_WINDOW) begin
                    r_window <= i_cfg_data;
                end else begin
                    r_interval <= i_cfg_data;
                end
            end
            if (out_acc && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_t <= i_event_time;
                        r_res <= '0;
                        if (i_req_type == thi_pkg::REQ_RECORD) begin
                            if (r_have && {1'b0, i_event_time} < gate) begin
                                r_found <= 1'b0;
                                r_state <= S_OUT;
                            end else begin
                                r_last <= i_event_time;
                                r_have <= 1'b1;
                                r_found <= 1'b1;
                                if (r_count == CW'(HISTORY_DEPTH)) begin
                                    r_oldest <= f_inc(r_oldest);
                                    r_idx <= f_inc(r_oldest);
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    r_idx <= r_oldest;
                                end
                                r_state <= S_DROP_RD;
                            end
                        end else begin
                            r_found <= 1'b0;
                            if (r_count == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_idx <= r_oldest;
                                r_state <= S_Q_OLD;
                            end
                        end
                    end
                end
                S_DROP_RD: r_state <= S_DROP_CK;
                S_DROP_CK: begin
                    if (r_count != '0 && old_plus < {1'b0, r_t}) begin
                        r_oldest <= f_inc(r_oldest);
                        r_idx <= f_inc(r_oldest);
                        r_count <= r_count - 1'b1;
                        r_state <= S_DROP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_Q_OLD: r_state <= S_Q_OLDCK;
                S_Q_OLDCK: begin
                    if (r_t <= rd.t) begin
                        r_res <= rd;
                        r_found <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= f_slot(r_oldest, r_count - 1'b1);
                        r_state <= S_Q_NEW;
                    end
                end
                S_Q_NEW: r_state <= S_Q_NEWCK;
                S_Q_NEWCK: begin
                    if (r_t >= rd.t) begin
                        r_state <= S_OUT;
                    end else begin
                        r_b <= rd;
                        r_k <= r_count - 1'b1;
                        r_idx <= f_dec(r_idx);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_k == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        // First visit after a read: rd holds the candidate earlier entry.
                        if (rd.t <= r_t) begin
                            r_a <= rd;
                            r_span <= {1'b0, r_b.t - rd.t};
                            r_rem <= NW'(r_t - rd.t) << ALPHA_BITS;
                            r_alpha <= '0;
                            r_bit <= AB'(1);
                        end else begin
                            r_b <= rd;
                            r_k <= r_k - 1'b1;
                            r_idx <= f_dec(r_idx);
                            r_state <= S_SCAN;
                        end
                    end else if (r_span == '0) begin
                        r_alpha <= '0;
                        r_fld <= '0;
                        r_bit <= '0;
                        r_state <= S_LERP_MUL;
                    end else begin
                        if ((r_rem >> (ALPHA_BITS + 1 - int'(r_bit))) >= NW'(r_span)) begin
                            r_rem <= r_rem - (NW'(r_span) << (ALPHA_BITS + 1 - int'(r_bit)));
                            r_alpha <= r_alpha | ((ALPHA_BITS+1)'(1)
                                       << (ALPHA_BITS + 1 - int'(r_bit)));
                        end
                        if (r_bit == AB'(ALPHA_BITS + 1)) begin
                            r_fld <= '0;
                            r_bit <= '0;
                            r_state <= S_LERP_MUL;
                        end else begin
                            r_bit <= r_bit + 1'b1;
                        end
                    end
                end
                S_LERP_MUL: begin
                    r_prod <= fdiff * $signed({1'b0, r_alpha});
                    r_state <= S_LERP_ADD;
                end
                S_LERP_ADD: begin
                    case (r_fld)
                        4'd0: r_res.x <= 32'(fa + fq);
                        4'd1: r_res.y <= 32'(fa + fq);
                        4'd2: r_res.z <= 32'(fa + fq);
                        4'd3: r_res.pitch <= 24'(fa + fq);
                        4'd4: r_res.yaw <= 24'(fa + fq);
                        4'd5: r_res.roll <= 24'(fa + fq);
                        4'd6: r_res.hh <= 24'(fa + fq);
                        default: r_res.rad <= 24'(fa + fq);
                    endcase
                    if (r_fld == 4'd7) begin
                        r_res.t <= r_t;
                        r_found <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_fld <= r_fld + 1'b1;
                        r_state <= S_LERP_MUL;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_found <= r_found;
                        o_out_time <= r_res.t;
                        o_out_x <= r_res.x;
                        o_out_y <= r_res.y;
                        o_out_z <= r_res.z;
                        o_out_pitch <= r_res.pitch;
                        o_out_yaw <= r_res.yaw;
                        o_out_roll <= r_res.roll;
                        o_out_half_height <= r_res.hh;
                        o_out_radius <= r_res.rad;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_SCAN) begin
                r_bit <= '0;
            end
        end
    end

    property p_cnt_max;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_count <= CW'(HISTORY_DEPTH);
    endproperty
    assert property (p_cnt_max) else $error("entry count exceeds depth");
    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DROP_CK) |=> (r_count <= $past(r_count));
    endproperty
    assert property (p_cnt) else $error("count grew while dropping");
    property p_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_OUT) |=> o_valid;
    endproperty
    assert property (p_out) else $error("result not shown");
    property p_acc;
        @(posedge i_clk) disable iff (!i_rst_n)
            in_acc |=> (r_state != S_IDLE);
    endproperty
    assert property (p_acc) else $error("accepted item not started");
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && !i_ready) |=> (o_valid && $stable(o_out_time) && $stable(o_found));
    endproperty
    assert property (p_hold) else $error("waiting result changed");
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the timestamped history interpolator with a scoreboard and random traffic.
`timescale 1ns / 100ps

typedef struct {
    bit               found;
    bit [31:0]        t;
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
    bit signed [23:0] pitch;
    bit signed [23:0] yaw;
    bit signed [23:0] roll;
    bit [23:0]        hh;
    bit [23:0]        rad;
} pose_t;

class pose_history_sb;
    bit [23:0]   window = thi_pkg::HISTORY_WINDOW_RST;
    bit [23:0]   interval = thi_pkg::RECORD_INTERVAL_RST;
    pose_t       ring[thi_pkg::HISTORY_DEPTH];
    int unsigned oldest;
    int unsigned count;
    bit [31:0]   last_t;
    bit          have_recorded;
    pose_t       awaited[$];
    int          mismatches;

    function void write_reg(bit [0:0] idx, bit [23:0] v);
        if (idx == thi_pkg::CFG_HISTORY_WINDOW) window = v;
        else interval = v;
    endfunction

    function longint mix(longint a, longint b, longint alpha);
        return a + (((b - a) * alpha) >>> thi_pkg::ALPHA_BITS);
    endfunction

    function pose_t blend(pose_t a, pose_t b, bit [31:0] t);
        pose_t  r;
        longint alpha;
        bit [31:0] span;
        span = b.t - a.t;
        alpha = 0;
        if (span > 0) begin
            alpha = (longint'(t - a.t) << thi_pkg::ALPHA_BITS) / span;
            if (alpha > (longint'(1) << thi_pkg::ALPHA_BITS))
                alpha = longint'(1) << thi_pkg::ALPHA_BITS;
        end
        r.found = 1;
        r.t = t;
        r.x = 32'(mix(a.x, b.x, alpha));
        r.y = 32'(mix(a.y, b.y, alpha));
        r.z = 32'(mix(a.z, b.z, alpha));
        r.pitch = 24'(mix(a.pitch, b.pitch, alpha));
        r.yaw = 24'(mix(a.yaw, b.yaw, alpha));
        r.roll = 24'(mix(a.roll, b.roll, alpha));
        r.hh = 24'(mix(a.hh, b.hh, alpha));
        r.rad = 24'(mix(a.rad, b.rad, alpha));
        return r;
    endfunction

    function void note_request(bit req, pose_t p);
        pose_t r;
        int unsigned w, ia, ib;
        r = '{default: 0};
        if (req == thi_pkg::REQ_RECORD) begin
            if (!(have_recorded && {32'd0, p.t} < {32'd0, last_t} + interval)) begin
                last_t = p.t;
                have_recorded = 1;
                if (count >= thi_pkg::HISTORY_DEPTH) begin
                    w = oldest;
                    oldest = (oldest + 1) % thi_pkg::HISTORY_DEPTH;
                end else begin
                    w = (oldest + count) % thi_pkg::HISTORY_DEPTH;
                    count++;
                end
                ring[w] = p;
                while (count > 0 && {32'd0, ring[oldest].t} + window < {32'd0, p.t}) begin
                    oldest = (oldest + 1) % thi_pkg::HISTORY_DEPTH;
                    count--;
                end
                r.found = 1;
            end
        end else if (count > 0) begin
            ib = (oldest + count - 1) % thi_pkg::HISTORY_DEPTH;
            if (p.t <= ring[oldest].t) begin
                r = ring[oldest];
                r.found = 1;
            end else if (p.t < ring[ib].t) begin
                for (int i = count - 1; i > 0; i--) begin
                    ia = (oldest + i - 1) % thi_pkg::HISTORY_DEPTH;
                    ib = (oldest + i) % thi_pkg::HISTORY_DEPTH;
                    if (ring[ia].t <= p.t && p.t <= ring[ib].t) begin
                        r = blend(ring[ia], ring[ib], p.t);
                        break;
                    end
                end
            end
        end
        awaited.push_back(r);
    endfunction

    function void check_result(pose_t got);
        pose_t e;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer");
            return;
        end
        e = awaited.pop_front();
        if (got.found != e.found || got.t != e.t || got.x != e.x || got.y != e.y ||
            got.z != e.z || got.pitch != e.pitch || got.yaw != e.yaw ||
            got.roll != e.roll || got.hh != e.hh || got.rad != e.rad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("exp found=%0d t=%h x=%h y=%h z=%h p=%h yw=%h r=%h hh=%h rad=%h",
                         e.found, e.t, e.x, e.y, e.z, e.pitch, e.yaw, e.roll, e.hh, e.rad);
                $display("got found=%0d t=%h x=%h y=%h z=%h p=%h yw=%h r=%h hh=%h rad=%h",
                         got.found, got.t, got.x, got.y, got.z, got.pitch, got.yaw,
                         got.roll, got.hh, got.rad);
            end
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_req_type = 0;
    logic [31:0] i_event_time = 0;
    logic signed [31:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic signed [23:0] i_pitch = 0, i_yaw = 0, i_roll = 0;
    logic [23:0] i_half_height = 0, i_radius = 0;
    logic i_cfg_valid = 0;
    logic [0:0] i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;
    logic i_ready = 0;
    logic o_ready, o_cfg_ready, o_valid, o_found;
    logic [31:0] o_out_time;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic signed [23:0] o_out_pitch, o_out_yaw, o_out_roll;
    logic [23:0] o_out_half_height, o_out_radius;

    pose_history_sb sb = new();
    int send_idle = 10;
    int recv_idle = 85;
    bit hold_req = 0;
    int hold_cnt = 0;
    int cycles = 0;
    longint now_us = 0;

    timestamped_history_interpolator i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[timestamped_history_interpolator] ERROR");
            $finish;
        end
    end

    // The receiver stalls on its own count when a long hold-off is requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        pose_t g;
        if (i_rst_n && o_valid && i_ready) begin
            g.found = o_found;
            g.t = o_out_time;
            g.x = o_out_x;
            g.y = o_out_y;
            g.z = o_out_z;
            g.pitch = o_out_pitch;
            g.yaw = o_out_yaw;
            g.roll = o_out_roll;
            g.hh = o_out_half_height;
            g.rad = o_out_radius;
            sb.check_result(g);
        end
    end

    function automatic pose_t rand_pose(bit [31:0] t);
        pose_t p;
        p.found = 0;
        p.t = t;
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
        p.pitch = 24'($urandom);
        p.yaw = 24'($urandom);
        p.roll = 24'($urandom);
        p.hh = 24'($urandom);
        p.rad = 24'($urandom);
        return p;
    endfunction

    function automatic pose_t edge_pose(bit [31:0] t, bit top);
        pose_t p;
        p.found = 0;
        p.t = t;
        p.x = top ? 32'h7fffffff : 32'h80000000;
        p.y = p.x;
        p.z = p.x;
        p.pitch = top ? 24'h7fffff : 24'h800000;
        p.yaw = p.pitch;
        p.roll = p.pitch;
        p.hh = top ? 24'hffffff : 24'h0;
        p.rad = p.hh;
        return p;
    endfunction

    task automatic send(bit req, pose_t p);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= req;
        i_event_time <= p.t;
        i_pos_x <= p.x;
        i_pos_y <= p.y;
        i_pos_z <= p.z;
        i_pitch <= p.pitch;
        i_yaw <= p.yaw;
        i_roll <= p.roll;
        i_half_height <= p.hh;
        i_radius <= p.rad;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req, p);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [0:0] idx, bit [23:0] v);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic run_random(int n, int step_max, int qspan);
        longint t;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                t = now_us + $urandom_range(step_max, 0);
                if (t > 64'hffffffff) t = 64'hffffffff;
                now_us = t;
                send(thi_pkg::REQ_RECORD, rand_pose(32'(t)));
            end else if (pick < 58) begin
                t = now_us - $urandom_range(step_max, 0);
                if (t < 0) t = 0;
                send(thi_pkg::REQ_RECORD, rand_pose(32'(t)));
            end else if (pick < 90) begin
                t = now_us - $urandom_range(qspan, 0);
                if (t < 0) t = 0;
                send(thi_pkg::REQ_QUERY, rand_pose(32'(t)));
            end else begin
                send(thi_pkg::REQ_QUERY, rand_pose($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(thi_pkg::REQ_QUERY, rand_pose(5));
        send(thi_pkg::REQ_RECORD, edge_pose(1000, 1));
        send(thi_pkg::REQ_QUERY, rand_pose(1000));
        send(thi_pkg::REQ_RECORD, rand_pose(17666));
        send(thi_pkg::REQ_RECORD, edge_pose(17667, 0));
        send(thi_pkg::REQ_QUERY, rand_pose(0));
        send(thi_pkg::REQ_QUERY, rand_pose(9000));
        send(thi_pkg::REQ_QUERY, rand_pose(17667));
        send(thi_pkg::REQ_QUERY, rand_pose(32'hffffffff));
        send(thi_pkg::REQ_RECORD, rand_pose(500));
        send(thi_pkg::REQ_RECORD, rand_pose(40000));
        send(thi_pkg::REQ_QUERY, rand_pose(30000));
        drain();

        write_reg(thi_pkg::CFG_HISTORY_WINDOW, 24'hffffff);
        write_reg(thi_pkg::CFG_RECORD_INTERVAL, 24'd0);
        send(thi_pkg::REQ_RECORD, edge_pose(40000, 0));
        send(thi_pkg::REQ_RECORD, edge_pose(40000, 1));
        send(thi_pkg::REQ_RECORD, edge_pose(50000, 0));
        send(thi_pkg::REQ_QUERY, rand_pose(40000));
        send(thi_pkg::REQ_QUERY, rand_pose(45000));
        now_us = 50000;
        hold_req = 1;
        run_random(450, 3000, 200000);
        drain();

        send_idle = 85;
        recv_idle = 10;
        write_reg(thi_pkg::CFG_HISTORY_WINDOW, 24'd5000);
        write_reg(thi_pkg::CFG_RECORD_INTERVAL, 24'd1000);
        run_random(450, 4000, 8000);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(thi_pkg::CFG_HISTORY_WINDOW, 24'd0);
        write_reg(thi_pkg::CFG_RECORD_INTERVAL, 24'hffffff);
        run_random(150, 1 << 25, 1 << 25);
        drain();

        write_reg(thi_pkg::CFG_HISTORY_WINDOW, 24'hffffff);
        write_reg(thi_pkg::CFG_RECORD_INTERVAL, 24'd0);
        run_random(400, 1 << 24, 1 << 23);
        drain();

        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("[timestamped_history_interpolator] OK");
        else
            $display("[timestamped_history_interpolator] ERROR");
        $finish;
    end
endmodule
